/* rtl/vse_pkg.sv */
package vse_pkg;

    // Event kinds carried on the input side band
    typedef enum logic [1:0] {
        MODE_FRAME = 2'd0,
        MODE_PUMP  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_COMP_THRESHOLD = 3'd0,
        REG_RISE_STEP      = 3'd1,
        REG_IDLE_DECAY     = 3'd2,
        REG_BRAKE_DECAY    = 3'd3,
        REG_FLOOR          = 3'd4,
        REG_CEILING        = 3'd5,
        REG_BRAKE_CEILING  = 3'd6,
        REG_RESPONSE_ID    = 3'd7
    } reg_idx_t;

    localparam int COUNTER_BITS_DEF = 4;
    localparam int ADDR_W           = 5;
    localparam int DATA_W           = 32;
    localparam int S_TDATA_W        = 40;
    localparam int M_TDATA_W        = 56;

    localparam logic [10:0] BRAKE_FRAME_ID   = 11'h20A;
    localparam logic [10:0] TRIGGER_FRAME_ID = 11'h318;
    localparam logic [1:0]  BRAKE_RELEASED   = 2'b01;

    localparam logic [15:0] RST_COMP_THRESHOLD = 16'd50000;
    localparam logic [15:0] RST_RISE_STEP      = 16'd262;
    localparam logic [15:0] RST_IDLE_DECAY     = 16'd65;
    localparam logic [15:0] RST_BRAKE_DECAY    = 16'd131;
    localparam logic [15:0] RST_FLOOR          = 16'd22281;
    localparam logic [15:0] RST_CEILING        = 16'd34078;
    localparam logic [15:0] RST_BRAKE_CEILING  = 16'd28835;
    localparam logic [10:0] RST_RESPONSE_ID    = 11'h556;

endpackage

/* rtl/vacuum_sensor_emulator.sv */
// Brake-booster vacuum sensor emulator.
// Input channel (s_*): one transaction per event; s_tuser holds the event
// kind (received frame, pump sample, transmit tick, bus error clear) and
// s_tdata the frame id, first frame byte, pump sample and mailbox flag.
// Output channel (m_*): exactly one transaction per input event, carrying
// the vacuum level (DAC drive), pump level, status byte, checksum byte and
// sticky send fault; m_tuser flags an emitted status frame. Status and
// checksum read zero when no frame goes out.
// Configuration: APB port, eight 32-bit registers at byte address 4*index,
// writes complete in the access cycle, pready tied high.
// Flow: an event is registered in the input register on acceptance and
// its result moves into the output register once that register is empty
// or being drained. Throughput: one event per cycle while the receiver
// keeps up, set by the single update path (add, subtract, two clamps, byte
// checksum) between the input register and the output register.
// Reset: all state clears to zero, configuration returns to its defaults,
// both stages empty. When the receiver stalls, the output register holds
// its result and the input register keeps taking one more event; after
// that s_tready drops until the output drains.
module vacuum_sensor_emulator #(
    parameter int COUNTER_BITS = vse_pkg::COUNTER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata: frame_id[10:0], frame_first_byte[18:11], pump_sample[34:19],
    //          mailbox_free[35], zero fill[39:36]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vse_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: mode[1:0]
    input  logic [1:0]                    s_tuser,
    // m_tdata: vacuum_level[15:0], pump_level[31:16], status_byte[39:32],
    //          checksum_byte[47:40], send_fault[48], zero fill[55:49]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vse_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: frame_valid[0]
    output logic                          m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vse_pkg::ADDR_W-1:0]    paddr,
    input  logic [vse_pkg::DATA_W-1:0]    pwdata,
    output logic [vse_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import vse_pkg::*;

    // Configuration registers
    logic [15:0] thresh_reg;
    logic [15:0] rise_reg;
    logic [15:0] idle_decay_reg;
    logic [15:0] brake_decay_reg;
    logic [15:0] floor_reg;
    logic [15:0] ceiling_reg;
    logic [15:0] brake_ceiling_reg;
    logic [10:0] resp_id_reg;

    // Input stage
    logic        in_valid_reg;
    mode_t       in_mode_reg;
    logic [10:0] in_id_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] in_sample_reg;
    logic        in_mfree_reg;

    // Emulator state
    logic [15:0]             level_reg, level_next;
    logic [15:0]             pump_reg, pump_next;
    logic                    brake_reg, brake_next;
    logic                    comp_reg, comp_next;
    logic [COUNTER_BITS-1:0] cnt_reg, cnt_next;
    logic                    fault_reg, fault_next;

    // Output stage
    logic        out_valid_reg;
    logic        out_frame_reg, out_frame_next;
    logic [7:0]  out_status_reg, out_status_next;
    logic [7:0]  out_csum_reg, out_csum_next;
    logic [15:0] out_level_reg;
    logic [15:0] out_pump_reg;
    logic        out_fault_reg;

    logic        advance;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    // Trigger path intermediates
    logic [15:0] rise_v;
    logic [15:0] decay_v;
    logic [15:0] ceil_v;
    logic [15:0] clamp_v;
    logic [15:0] floor_v;
    logic [7:0]  status_v;
    logic [3:0]  cnt_wide;

    //------------------------------------------------------------------
    // Configuration port
    //------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg        <= RST_COMP_THRESHOLD;
            rise_reg          <= RST_RISE_STEP;
            idle_decay_reg    <= RST_IDLE_DECAY;
            brake_decay_reg   <= RST_BRAKE_DECAY;
            floor_reg         <= RST_FLOOR;
            ceiling_reg       <= RST_CEILING;
            brake_ceiling_reg <= RST_BRAKE_CEILING;
            resp_id_reg       <= RST_RESPONSE_ID;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_COMP_THRESHOLD: thresh_reg        <= pwdata[15:0];
                REG_RISE_STEP:      rise_reg          <= pwdata[15:0];
                REG_IDLE_DECAY:     idle_decay_reg    <= pwdata[15:0];
                REG_BRAKE_DECAY:    brake_decay_reg   <= pwdata[15:0];
                REG_FLOOR:          floor_reg         <= pwdata[15:0];
                REG_CEILING:        ceiling_reg       <= pwdata[15:0];
                REG_BRAKE_CEILING:  brake_ceiling_reg <= pwdata[15:0];
                REG_RESPONSE_ID:    resp_id_reg       <= pwdata[10:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_COMP_THRESHOLD: prdata = {16'd0, thresh_reg};
            REG_RISE_STEP:      prdata = {16'd0, rise_reg};
            REG_IDLE_DECAY:     prdata = {16'd0, idle_decay_reg};
            REG_BRAKE_DECAY:    prdata = {16'd0, brake_decay_reg};
            REG_FLOOR:          prdata = {16'd0, floor_reg};
            REG_CEILING:        prdata = {16'd0, ceiling_reg};
            REG_BRAKE_CEILING:  prdata = {16'd0, brake_ceiling_reg};
            REG_RESPONSE_ID:    prdata = {21'd0, resp_id_reg};
            default:            prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Handshake: the input stage moves on whenever the output register is
    // empty or being drained this cycle.
    //------------------------------------------------------------------
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg   <= mode_t'(s_tuser);
            in_id_reg     <= s_tdata[10:0];
            in_byte_reg   <= s_tdata[18:11];
            in_sample_reg <= s_tdata[34:19];
            in_mfree_reg  <= s_tdata[35];
        end
    end

    //------------------------------------------------------------------
    // Trigger update: rise, decay, ceiling clamp, then floor (floor wins)
    //------------------------------------------------------------------
    always_comb
    begin
        rise_v  = comp_reg ? (level_reg + rise_reg) : level_reg;
        decay_v = rise_v - (brake_reg ? brake_decay_reg : idle_decay_reg);
        ceil_v  = brake_reg ? brake_ceiling_reg : ceiling_reg;
        clamp_v = (decay_v > ceil_v) ? ceil_v : decay_v;
        floor_v = (clamp_v < floor_reg) ? floor_reg : clamp_v;
    end

    // Status byte carries the counter value before it steps
    assign cnt_wide = 4'(cnt_reg);
    assign status_v = {cnt_wide, 1'b0, 1'b1, comp_reg, brake_reg};

    //------------------------------------------------------------------
    // Per-event state update and result
    //------------------------------------------------------------------
    always_comb
    begin
        level_next      = level_reg;
        pump_next       = pump_reg;
        brake_next      = brake_reg;
        comp_next       = comp_reg;
        cnt_next        = cnt_reg;
        fault_next      = fault_reg;
        out_frame_next  = 1'b0;
        out_status_next = 8'd0;
        out_csum_next   = 8'd0;
        case (in_mode_reg)
            MODE_FRAME:
            begin
                if (in_id_reg == BRAKE_FRAME_ID)
                begin
                    brake_next = (in_byte_reg[3:2] != BRAKE_RELEASED);
                end
                if (in_id_reg == TRIGGER_FRAME_ID)
                begin
                    level_next = floor_v;
                end
            end
            MODE_PUMP:
            begin
                pump_next = {2'b00, in_sample_reg[15:2]};
                comp_next = (pump_next >= thresh_reg);
            end
            MODE_TICK:
            begin
                if (in_mfree_reg)
                begin
                    out_frame_next  = 1'b1;
                    out_status_next = status_v;
                    // Byte sum wraps modulo 256 in the 8-bit adder chain
                    out_csum_next   = resp_id_reg[7:0] + {5'd0, resp_id_reg[10:8]}
                                    + level_reg[7:0] + level_reg[15:8]
                                    + pump_reg[7:0] + pump_reg[15:8]
                                    + status_v;
                    cnt_next        = cnt_reg + COUNTER_BITS'(1);
                end
                else
                begin
                    fault_next = 1'b1;
                end
            end
            MODE_CLEAR:
            begin
                fault_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            pump_reg  <= '0;
            brake_reg <= 1'b0;
            comp_reg  <= 1'b0;
            cnt_reg   <= '0;
            fault_reg <= 1'b0;
        end
        else if (advance)
        begin
            level_reg <= level_next;
            pump_reg  <= pump_next;
            brake_reg <= brake_next;
            comp_reg  <= comp_next;
            cnt_reg   <= cnt_next;
            fault_reg <= fault_next;
        end
    end

    //------------------------------------------------------------------
    // Output register
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_frame_reg  <= out_frame_next;
            out_status_reg <= out_status_next;
            out_csum_reg   <= out_csum_next;
            out_level_reg  <= level_next;
            out_pump_reg   <= pump_next;
            out_fault_reg  <= fault_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_frame_reg;
    assign m_tdata  = {7'd0, out_fault_reg, out_csum_reg, out_status_reg,
                       out_pump_reg, out_level_reg};

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    // No frame emitted: status and checksum must read zero
    a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[47:32] == 16'd0))
        else $error("status or checksum nonzero without a frame");

    // An emitted frame always carries the ok bit
    a_ok_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tdata[34])
        else $error("emitted frame without ok bit");

    // A tick that finds the mailbox busy leaves the send fault set
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_mode_reg == MODE_TICK) && !in_mfree_reg) |=> fault_reg)
        else $error("busy mailbox did not set send fault");

    // After a trigger the level never lies below the floor
    a_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_mode_reg == MODE_FRAME) && (in_id_reg == TRIGGER_FRAME_ID))
        |=> (level_reg >= $past(floor_reg)))
        else $error("level below floor after trigger");

endmodule

/* sim/vse_checker.sv */
module vse_checker
    import vse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output int                   fail_count,
    output int                   result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        frame_valid;
        logic [15:0] vacuum_level;
        logic [15:0] pump_level;
        logic [7:0]  status_byte;
        logic [7:0]  checksum_byte;
        logic        send_fault;
    } sensor_out_t;

    // Shadow of the configuration registers
    logic [15:0] cfg_threshold;
    logic [15:0] cfg_rise;
    logic [15:0] cfg_idle_decay;
    logic [15:0] cfg_brake_decay;
    logic [15:0] cfg_floor;
    logic [15:0] cfg_ceiling;
    logic [15:0] cfg_brake_ceiling;
    logic [10:0] cfg_response_id;

    // Emulated sensor state
    logic [15:0] level;
    logic [15:0] pump;
    logic        brake_on;
    logic        comp_running;
    logic [3:0]  rolling_count;
    logic        fault;

    sensor_out_t expected_status[$];
    int          mismatches;
    int          accepted;

    // Advance the emulated sensor by one event and return what it reports.
    function automatic sensor_out_t advance_sensor(mode_t mode, logic [S_TDATA_W-1:0] data);
        sensor_out_t res;
        logic [10:0] fid;
        logic [7:0]  fbyte;
        logic [15:0] v;
        res   = '0;
        fid   = data[10:0];
        fbyte = data[18:11];
        case (mode)
            MODE_FRAME:
            begin
                if (fid == BRAKE_FRAME_ID)
                begin
                    brake_on = (fbyte[3:2] != BRAKE_RELEASED);
                end
                if (fid == TRIGGER_FRAME_ID)
                begin
                    v = level;
                    if (comp_running)
                    begin
                        v = v + cfg_rise;
                    end
                    if (brake_on)
                    begin
                        v = v - cfg_brake_decay;
                        if (v > cfg_brake_ceiling)
                        begin
                            v = cfg_brake_ceiling;
                        end
                    end
                    else
                    begin
                        v = v - cfg_idle_decay;
                        if (v > cfg_ceiling)
                        begin
                            v = cfg_ceiling;
                        end
                    end
                    // floor is applied last, so it wins over a lower ceiling
                    if (v < cfg_floor)
                    begin
                        v = cfg_floor;
                    end
                    level = v;
                end
            end
            MODE_PUMP:
            begin
                pump         = {2'b00, data[34:21]};
                comp_running = (pump >= cfg_threshold);
            end
            MODE_TICK:
            begin
                if (data[35])
                begin
                    res.frame_valid   = 1'b1;
                    res.status_byte   = {rolling_count, 1'b0, 1'b1, comp_running, brake_on};
                    res.checksum_byte = cfg_response_id[7:0] + {5'd0, cfg_response_id[10:8]}
                                      + level[7:0] + level[15:8] + pump[7:0] + pump[15:8]
                                      + res.status_byte;
                    rolling_count     = rolling_count + 4'd1;
                end
                else
                begin
                    fault = 1'b1;
                end
            end
            MODE_CLEAR:
            begin
                fault = 1'b0;
            end
            default: ;
        endcase
        res.vacuum_level = level;
        res.pump_level   = pump;
        res.send_fault   = fault;
        return res;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sensor_out_t want;
        if (!rst_n)
        begin
            cfg_threshold     = RST_COMP_THRESHOLD;
            cfg_rise          = RST_RISE_STEP;
            cfg_idle_decay    = RST_IDLE_DECAY;
            cfg_brake_decay   = RST_BRAKE_DECAY;
            cfg_floor         = RST_FLOOR;
            cfg_ceiling       = RST_CEILING;
            cfg_brake_ceiling = RST_BRAKE_CEILING;
            cfg_response_id   = RST_RESPONSE_ID;
            level             = '0;
            pump              = '0;
            brake_on          = 1'b0;
            comp_running      = 1'b0;
            rolling_count     = '0;
            fault             = 1'b0;
            mismatches        = 0;
            accepted          = 0;
            expected_status.delete();
            fail_count   <= 0;
            result_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_COMP_THRESHOLD: cfg_threshold     = pwdata[15:0];
                    REG_RISE_STEP:      cfg_rise          = pwdata[15:0];
                    REG_IDLE_DECAY:     cfg_idle_decay    = pwdata[15:0];
                    REG_BRAKE_DECAY:    cfg_brake_decay   = pwdata[15:0];
                    REG_FLOOR:          cfg_floor         = pwdata[15:0];
                    REG_CEILING:        cfg_ceiling       = pwdata[15:0];
                    REG_BRAKE_CEILING:  cfg_brake_ceiling = pwdata[15:0];
                    REG_RESPONSE_ID:    cfg_response_id   = pwdata[10:0];
                    default:            ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                expected_status.push_back(advance_sensor(mode_t'(s_tuser), s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                accepted++;
                if (expected_status.size() == 0)
                begin
                    $error("result transaction with no event outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("frame_valid",   want.frame_valid,   m_tuser);
                    check_field("vacuum_level",  want.vacuum_level,  m_tdata[15:0]);
                    check_field("pump_level",    want.pump_level,    m_tdata[31:16]);
                    check_field("status_byte",   want.status_byte,   m_tdata[39:32]);
                    check_field("checksum_byte", want.checksum_byte, m_tdata[47:40]);
                    check_field("send_fault",    want.send_fault,    m_tdata[48]);
                end
            end
            // outstanding expectations count against the run until they arrive
            fail_count   <= mismatches + expected_status.size();
            result_count <= accepted;
        end
    end

endmodule

/* sim/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import vse_pkg::*;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // s_tdata: frame_id[10:0], frame_first_byte[18:11], pump_sample[34:19],
    //          mailbox_free[35], zero fill[39:36]
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // s_tuser: mode[1:0]
    logic [1:0]           s_tuser  = MODE_FRAME;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // m_tdata: vacuum_level[15:0], pump_level[31:16], status_byte[39:32],
    //          checksum_byte[47:40], send_fault[48], zero fill[55:49]
    logic [M_TDATA_W-1:0] m_tdata;
    // m_tuser: frame_valid[0]
    logic                 m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_W-1:0]    paddr    = '0;
    logic [DATA_W-1:0]    pwdata   = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    int                   fail_count;
    int                   result_count;
    int                   sent_count = 0;
    // While high, neither side inserts idle cycles
    logic                 quiet      = 1'b0;
    // Pump level the current phase uses as its compressor threshold
    logic [15:0]          pump_hint  = RST_COMP_THRESHOLD;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    vacuum_sensor_emulator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    vse_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .result_count (result_count)
    );

    // Receiver: stall at random about 9 times in a hundred, never during a quiet stretch.
    always @(posedge clk)
    begin
        m_tready <= quiet || ($urandom_range(99) >= 9);
    end

    // Post one event transaction. Idle the sender first now and then, hold
    // the transaction until the block takes it, and leave tvalid high so
    // back-to-back events stream without a bubble.
    task automatic post_event(input mode_t mode, input logic [10:0] fid,
                              input logic [7:0] fbyte, input logic [15:0] sample,
                              input logic mbox);
        while (!quiet && $urandom_range(99) < 9)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'd0, mbox, sample, fbyte, fid};
        do
            @(posedge clk);
        while (!s_tready);
        sent_count++;
    endtask

    // Drop tvalid and wait until every posted event has produced its result.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (result_count != sent_count);
    endtask

    // One APB write: setup cycle, then access cycle until pready.
    task automatic reg_write(input reg_idx_t idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    // Rewrite the whole register set back to back, then release the bus.
    task automatic load_settings(input logic [15:0] threshold, input logic [15:0] rise,
                                 input logic [15:0] idle_decay, input logic [15:0] brake_decay,
                                 input logic [15:0] floor_lvl, input logic [15:0] ceiling_lvl,
                                 input logic [15:0] brake_ceiling_lvl,
                                 input logic [10:0] resp_id);
        reg_write(REG_COMP_THRESHOLD, threshold);
        reg_write(REG_RISE_STEP,      rise);
        reg_write(REG_IDLE_DECAY,     idle_decay);
        reg_write(REG_BRAKE_DECAY,    brake_decay);
        reg_write(REG_FLOOR,          floor_lvl);
        reg_write(REG_CEILING,        ceiling_lvl);
        reg_write(REG_BRAKE_CEILING,  brake_ceiling_lvl);
        reg_write(REG_RESPONSE_ID,    {5'd0, resp_id});
        psel      <= 1'b0;
        penable   <= 1'b0;
        pump_hint <= threshold;
    endtask

    // Mostly meaningful bus traffic: brake and trigger frames, pump samples
    // around the threshold, ticks with the mailbox usually free; the rest is
    // foreign frames, arbitrary samples and error clears. Unused fields
    // always carry random bits.
    task automatic random_events(input int count);
        logic [10:0] fid;
        logic [7:0]  fbyte;
        logic [15:0] sample;
        logic        mbox;
        int          pick;
        mode_t       mode;
        for (int n = 0; n < count; n++)
        begin
            fid    = 11'($urandom);
            fbyte  = 8'($urandom);
            sample = 16'($urandom);
            mbox   = ($urandom_range(99) < 85);
            pick   = $urandom_range(99);
            if (pick < 45)
            begin
                mode = MODE_FRAME;
                pick = $urandom_range(99);
                if (pick < 35)
                begin
                    fid = BRAKE_FRAME_ID;
                end
                else if (pick < 85)
                begin
                    fid = TRIGGER_FRAME_ID;
                end
            end
            else if (pick < 65)
            begin
                mode = MODE_PUMP;
                // land just below, on or just above the threshold
                if ($urandom_range(1) == 1)
                begin
                    sample = {pump_hint[13:0] + 14'($urandom_range(6)) - 14'd3,
                              2'($urandom)};
                end
            end
            else if (pick < 90)
            begin
                mode = MODE_TICK;
            end
            else
            begin
                mode = MODE_CLEAR;
            end
            post_event(mode, fid, fbyte, sample, mbox);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed events on the reset register set.
        post_event(MODE_TICK,  11'h000, 8'h00, 16'h0000, 1'b1);
        post_event(MODE_TICK,  11'h7FF, 8'hFF, 16'hFFFF, 1'b0);   // busy mailbox: fault
        post_event(MODE_TICK,  11'h000, 8'h00, 16'h0000, 1'b1);   // fault stays set
        post_event(MODE_CLEAR, 11'h7FF, 8'hFF, 16'hFFFF, 1'b1);
        post_event(MODE_PUMP,  11'h000, 8'h00, 16'hFFFF, 1'b0);
        post_event(MODE_PUMP,  11'h7FF, 8'hFF, 16'h0000, 1'b1);
        post_event(MODE_FRAME, BRAKE_FRAME_ID, 8'h04, 16'h0000, 1'b0);   // released
        post_event(MODE_FRAME, BRAKE_FRAME_ID, 8'h00, 16'hFFFF, 1'b1);   // pressed
        post_event(MODE_FRAME, TRIGGER_FRAME_ID, 8'h00, 16'h0000, 1'b0); // wrap, clamp
        post_event(MODE_FRAME, BRAKE_FRAME_ID, 8'h08, 16'h0000, 1'b0);
        post_event(MODE_FRAME, BRAKE_FRAME_ID, 8'hF7, 16'h0000, 1'b0);   // released
        post_event(MODE_FRAME, TRIGGER_FRAME_ID, 8'hFF, 16'h0000, 1'b0);
        post_event(MODE_FRAME, BRAKE_FRAME_ID, 8'h0C, 16'h0000, 1'b0);
        post_event(MODE_FRAME, 11'h7FF, 8'hFF, 16'hFFFF, 1'b1);          // foreign ids
        post_event(MODE_FRAME, 11'h000, 8'h00, 16'h0000, 1'b0);
        post_event(MODE_FRAME, 11'h20B, 8'h00, 16'h0000, 1'b0);
        post_event(MODE_FRAME, TRIGGER_FRAME_ID, 8'h00, 16'h0000, 1'b0);
        post_event(MODE_TICK,  11'h7FF, 8'hFF, 16'hFFFF, 1'b1);
        post_event(MODE_TICK,  11'h000, 8'h00, 16'h0000, 1'b1);
        random_events(60);
        drain();

        // Low extremes: compressor always on, rise wraps down by one, no decay.
        load_settings(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 11'h7FF);
        random_events(110);
        drain();

        // High extremes: compressor never on, floor above both ceilings.
        load_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 11'h000);
        random_events(100);
        drain();

        // Plausible booster with no idling on either side.
        load_settings(16'd8000, 16'd700, 16'd65, 16'd400, 16'd20000, 16'd34000, 16'd28000,
                      RST_RESPONSE_ID);
        quiet <= 1'b1;
        random_events(130);
        drain();
        quiet <= 1'b0;

        // Random settings with the floor below the idle ceiling, then two random sets with the threshold below 16384.
        for (int phase = 0; phase < 3; phase++)
        begin
            logic [15:0] floor_lvl;
            floor_lvl = 16'($urandom_range(30000));
            if (phase == 0)
            begin
                load_settings(16'($urandom_range(16383)), 16'($urandom_range(3000)),
                              16'($urandom_range(2000)), 16'($urandom_range(2000)),
                              floor_lvl, floor_lvl + 16'($urandom_range(30000)),
                              16'($urandom), 11'($urandom));
            end
            else
            begin
                load_settings(16'($urandom_range(16383)), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              11'($urandom));
            end
            random_events(100);
            drain();
        end

        // Let any stray result show up before the verdict.
        repeat (4) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: reports mismatches and ends the run if the test hangs.
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
